FILE: hdl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Types and constants shared by the least-frequently-used cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int LFU_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = 32;
    localparam int STAMP_W     = 48;
    localparam int CAP_W       = 5;

    localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0]  MISS_VALUE = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_INIT = 32'd1;

    // register index decoded from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] lookup_key;
        logic signed [31:0] store_value;
    } s_payload_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
    } m_payload_t;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  value;
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // control into the slot scanner
    typedef struct packed {
        logic   start;
        logic   slot_vld;
        entry_t slot;
    } scan_in_t;

    // summary of one full pass over the table
    typedef struct packed {
        logic               hit_found;
        logic [DATA_W-1:0]  hit_value;
        logic [COUNT_W-1:0] hit_count;
        logic               free_found;
        logic               vic_found;
    } scan_res_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_EVICT,
        ST_RESP
    } lfu_state_t;

endpackage

FILE: hdl/lfu_scan.sv
// ----------------------------------------------------------------------------
// lfu_scan
// Walks the table one slot per cycle and keeps the first key match, the
// first free slot and the eviction victim (lowest count, then oldest stamp).
// ----------------------------------------------------------------------------
module lfu_scan
    import lfu_pkg::*;
#(
    parameter int IDX_W = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  scan_in_t         scan_in,
    input  logic [IDX_W-1:0] slot_idx,
    input  logic [KEY_W-1:0] key,
    output scan_res_t        scan_res,
    output logic [IDX_W-1:0] hit_idx,
    output logic [IDX_W-1:0] free_idx,
    output logic [IDX_W-1:0] vic_idx
);

    logic               hit_found_reg, hit_found_next;
    logic               free_found_reg, free_found_next;
    logic               vic_found_reg, vic_found_next;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [DATA_W-1:0]  hit_value_reg;
    logic [COUNT_W-1:0] hit_count_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [IDX_W-1:0]   vic_idx_reg;
    logic [COUNT_W-1:0] vic_count_reg;
    logic [STAMP_W-1:0] vic_stamp_reg;

    logic take_hit;
    logic take_free;
    logic take_vic;

    always_comb begin
        take_hit  = scan_in.slot_vld && scan_in.slot.valid &&
                    (scan_in.slot.key == key) && !hit_found_reg;
        take_free = scan_in.slot_vld && !scan_in.slot.valid && !free_found_reg;
        take_vic  = scan_in.slot_vld && scan_in.slot.valid &&
                    (!vic_found_reg ||
                     (scan_in.slot.count < vic_count_reg) ||
                     ((scan_in.slot.count == vic_count_reg) &&
                      (scan_in.slot.stamp < vic_stamp_reg)));

        hit_found_next  = hit_found_reg  || take_hit;
        free_found_next = free_found_reg || take_free;
        vic_found_next  = vic_found_reg  || take_vic;
        if (scan_in.start) begin
            hit_found_next  = 1'b0;
            free_found_next = 1'b0;
            vic_found_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
        end else begin
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            vic_found_reg  <= vic_found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_hit) begin
            hit_idx_reg   <= slot_idx;
            hit_value_reg <= scan_in.slot.value;
            hit_count_reg <= scan_in.slot.count;
        end
        if (take_free) begin
            free_idx_reg <= slot_idx;
        end
        if (take_vic) begin
            vic_idx_reg   <= slot_idx;
            vic_count_reg <= scan_in.slot.count;
            vic_stamp_reg <= scan_in.slot.stamp;
        end
    end

    assign scan_res.hit_found  = hit_found_reg;
    assign scan_res.hit_value  = hit_value_reg;
    assign scan_res.hit_count  = hit_count_reg;
    assign scan_res.free_found = free_found_reg;
    assign scan_res.vic_found  = vic_found_reg;
    assign hit_idx  = hit_idx_reg;
    assign free_idx = free_idx_reg;
    assign vic_idx  = vic_idx_reg;

endmodule

FILE: hdl/lfu_cache_table.sv
// ----------------------------------------------------------------------------
// lfu_cache_table
// Key-value table with least-frequently-used replacement, APB capacity reg.
// ----------------------------------------------------------------------------
// flow: an accepted transaction scans every slot through the single table read
//   port, one entry per cycle, then updates the table and responds; a set that
//   must free a victim that is not the slot it fills adds an evict step, and at
//   capacity 0 the scan is skipped; a new transaction is taken only in idle
// reset: a clearing pass writes every entry invalid before the first input
//   transaction is taken; capacity resets to 16
module lfu_cache_table
    import lfu_pkg::*;
#(
    parameter int ENTRIES = LFU_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  s_payload_t  s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output m_payload_t  m_payload,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);
    localparam logic [CMP_W-1:0] CAP_MAX  = CMP_W'(ENTRIES);

    // table storage
    entry_t mem [ENTRIES];
    entry_t rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    lfu_state_t state_reg, state_next;
    logic [CAP_W-1:0]   capacity_reg;
    logic [IDX_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [CNT_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    s_payload_t         item_reg, item_next;
    m_payload_t         res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    m_payload_t         m_data_reg, m_data_next;

    scan_in_t         scan_in;
    scan_res_t        scan_res;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] vic_idx;

    logic [CMP_W-1:0]   cap_eff;
    logic               table_full;
    logic [COUNT_W-1:0] count_inc;
    logic               cfg_wr;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY) begin
            prdata = 32'(capacity_reg);
        end
    end

    // ------------------------------------------------------------------
    // table memory, one write and one registered read per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    lfu_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .scan_in  (scan_in),
        .slot_idx (rd_idx_reg),
        .key      (item_reg.lookup_key),
        .scan_res (scan_res),
        .hit_idx  (hit_idx),
        .free_idx (free_idx),
        .vic_idx  (vic_idx)
    );

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    always_comb begin
        cap_eff = CMP_W'(capacity_reg);
        if (cap_eff > CAP_MAX) begin
            cap_eff = CAP_MAX;
        end
        table_full = (CMP_W'(occ_reg) >= cap_eff) && scan_res.vic_found;
        count_inc  = (scan_res.hit_count == COUNT_MAX) ? COUNT_MAX
                                                       : scan_res.hit_count + 1'b1;
    end

    always_comb begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        scan_cnt_next = scan_cnt_reg;
        rd_pend_next  = 1'b0;
        rd_idx_next   = rd_idx_reg;
        occ_next      = occ_reg;
        stamp_next    = stamp_reg;
        item_next     = item_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        s_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = clr_idx_reg;
        mem_wdata = '0;
        mem_raddr = scan_cnt_reg[IDX_W-1:0];

        scan_in.start    = 1'b0;
        scan_in.slot_vld = rd_pend_reg;
        scan_in.slot     = rdata_reg;

        case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == IDX_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next          = s_payload;
                    res_next.hit       = 1'b0;
                    res_next.read_value = MISS_VALUE;
                    if (cap_eff == '0) begin
                        state_next = ST_RESP;
                    end else begin
                        scan_cnt_next = '0;
                        scan_in.start = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // read slot n while slot n-1 is being evaluated
                if (scan_cnt_reg != CNT_END) begin
                    rd_pend_next  = 1'b1;
                    rd_idx_next   = scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end else if (!rd_pend_reg) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = ST_RESP;
                mem_wdata.valid = 1'b1;
                mem_wdata.key   = item_reg.lookup_key;
                mem_wdata.stamp = stamp_reg;
                if (scan_res.hit_found) begin
                    mem_we          = 1'b1;
                    mem_waddr       = hit_idx;
                    mem_wdata.count = count_inc;
                    mem_wdata.value = (item_reg.opcode == OP_SET) ? item_reg.store_value
                                                                  : scan_res.hit_value;
                    stamp_next   = stamp_reg + 1'b1;
                    res_next.hit = 1'b1;
                    if (item_reg.opcode == OP_GET) begin
                        res_next.read_value = scan_res.hit_value;
                    end
                end else if (item_reg.opcode == OP_SET) begin
                    mem_wdata.count = COUNT_INIT;
                    mem_wdata.value = item_reg.store_value;
                    if (table_full) begin
                        // lower of free and victim slot wins; victim is dropped
                        mem_we     = 1'b1;
                        stamp_next = stamp_reg + 1'b1;
                        if (scan_res.free_found && (free_idx < vic_idx)) begin
                            mem_waddr  = free_idx;
                            state_next = ST_EVICT;
                        end else begin
                            mem_waddr = vic_idx;
                        end
                    end else if (scan_res.free_found) begin
                        mem_we     = 1'b1;
                        mem_waddr  = free_idx;
                        stamp_next = stamp_reg + 1'b1;
                        occ_next   = occ_reg + 1'b1;
                    end
                end
            end
            ST_EVICT: begin
                mem_we    = 1'b1;
                mem_waddr = vic_idx;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            scan_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
            occ_reg      <= '0;
            stamp_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            scan_cnt_reg <= scan_cnt_next;
            rd_pend_reg  <= rd_pend_next;
            occ_reg      <= occ_next;
            stamp_reg    <= stamp_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        item_reg   <= item_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_END)
        else $error("occupancy above table size");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !mem_we)
        else $error("table write while a scan is in flight");

    a_accept_starts_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> ((state_reg == ST_SCAN) || (state_reg == ST_RESP)))
        else $error("accepted transaction not picked up");

    a_stamp_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_UPDATE) |=> (stamp_reg == $past(stamp_reg)))
        else $error("stamp moved outside the update step");

endmodule
